FILE: rtl/core/segment_convex_polygon_clip_length_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the clip length block.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_CONVEX_POLYGON_CLIP_LENGTH_MACROS_SVH
`define SEGMENT_CONVEX_POLYGON_CLIP_LENGTH_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCPCL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scpcl same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SCPCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scpcl next-cycle check failed");

`endif

FILE: rtl/core/scpcl_pkg.sv
// ----------------------------------------------------------------------------
// Clip length package
// Widths, constants and the word type carried along the divider chain.
// ----------------------------------------------------------------------------
package scpcl_pkg;

	localparam int COORD_W = 16;
	localparam int DIFF_W = 17;
	localparam int PROD_W = 34;
	localparam int CROSS_W = 35;
	localparam int ACC_W = 48;
	localparam int FRAC_W = 32;
	localparam int BOUND_W = 33;
	localparam int RAD_W = 34;
	localparam int ROOT_W = 33;
	localparam int LEN_W = 33;
	localparam int CFG_W = 10;
	localparam int MIN_VERTICES = 3;
	localparam int FA_W = ROOT_W + 17;
	localparam int FB_W = ROOT_W + 16;
	localparam int SUM_W = FA_W + 1;

	localparam logic [BOUND_W-1:0] BOUND_ONE = 33'h1_0000_0000;
	localparam logic [SUM_W-1:0] ROUND_HALF = 51'h8000;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [CROSS_W-1:0] cross_t;

	typedef struct packed {
		logic valid;
		logic is_lo;
		logic [CROSS_W-1:0] rem;
		logic [CROSS_W-1:0] den;
		logic [FRAC_W-1:0] quo;
	} div_word_t;

endpackage

FILE: rtl/core/scpcl_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module scpcl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/scpcl_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// One restoring step of a fraction divide, registered toward the next cell.
// ----------------------------------------------------------------------------
module scpcl_div_cell import scpcl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input div_word_t d_in,
	output div_word_t d_out
);

	logic [CROSS_W:0] rem2;
	logic [CROSS_W:0] diff;
	logic ge;
	logic valid_q;
	logic is_lo_q;
	logic [CROSS_W-1:0] rem_q;
	logic [CROSS_W-1:0] den_q;
	logic [FRAC_W-1:0] quo_q;

	always_comb begin
		rem2 = {d_in.rem, 1'b0};
		diff = rem2 - {1'b0, d_in.den};
		ge = (rem2 >= {1'b0, d_in.den});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= d_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		is_lo_q <= d_in.is_lo;
		den_q <= d_in.den;
		rem_q <= ge ? diff[CROSS_W-1:0] : rem2[CROSS_W-1:0];
		quo_q <= {d_in.quo[FRAC_W-2:0], ge};
	end

	assign d_out.valid = valid_q;
	assign d_out.is_lo = is_lo_q;
	assign d_out.rem = rem_q;
	assign d_out.den = den_q;
	assign d_out.quo = quo_q;

endmodule

FILE: rtl/core/scpcl_sqrt.sv
// ----------------------------------------------------------------------------
// Square root unit
// Bit-pair restoring square root giving the length in Q16, one bit a cycle.
// ----------------------------------------------------------------------------
module scpcl_sqrt import scpcl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [RAD_W-1:0] radicand,
	output logic done,
	output logic [ROOT_W-1:0] root
);

	localparam int SRC_W = 2 * ROOT_W;
	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic [SRC_W-1:0] src_q;
	logic [RAD_W-1:0] r_q;
	logic [ROOT_W-1:0] q_q;
	logic [CNT_W-1:0] cnt_q;
	logic run_q;
	logic done_q;
	logic [RAD_W+1:0] r4;
	logic [RAD_W+1:0] trial;
	logic [RAD_W+1:0] rsub;
	logic ge;

	always_comb begin
		r4 = {r_q, src_q[SRC_W-1 -: 2]};
		trial = (RAD_W + 2)'({q_q, 2'b01});
		rsub = r4 - trial;
		ge = (r4 >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= CNT_W'(ROOT_W);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				run_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			src_q <= {radicand, {(SRC_W - RAD_W){1'b0}}};
			r_q <= '0;
			q_q <= '0;
		end else if (run_q) begin
			src_q <= {src_q[SRC_W-3:0], 2'b00};
			r_q <= ge ? rsub[RAD_W-1:0] : r4[RAD_W-1:0];
			q_q <= {q_q[ROOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = q_q;

endmodule

FILE: rtl/core/segment_convex_polygon_clip_length.sv
// Each vertex load is one accepted start with mode low; the last load starts an in-place sort.
// A query runs an area pass and then a clip pass over the edges on two shared 17x17
// multipliers, drains the 32-cell divider chain and ends in the states ST_FIN1 and ST_FIN2.
// A query before the polygon is complete answers with a zero length. The result strobe is high
// for one cycle and cannot be held off. Reset clears the control state and sets the
// vertex count to 3; the vertex store holds nothing until written.
// ----------------------------------------------------------------------------
// Segment clip length against a convex polygon
// Loads polygon vertices, sorts them about the first one, and returns the
// length of a segment lying strictly inside the polygon in Q16.
// ----------------------------------------------------------------------------
module segment_convex_polygon_clip_length import scpcl_pkg::*; #(
	parameter int MAX_VERTICES = 512
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_W-1:0] vertex_count,
	input logic start,
	output logic busy,
	input logic mode,
	input logic signed [COORD_W-1:0] x_a,
	input logic signed [COORD_W-1:0] y_a,
	input logic signed [COORD_W-1:0] x_b,
	input logic signed [COORD_W-1:0] y_b,
	output logic result_strobe,
	output logic [LEN_W-1:0] inside_length
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int FW = $clog2(MAX_VERTICES + 2);
	localparam int IFW = 6;

	typedef enum logic [11:0] {
		ST_IDLE     = 12'b0000_0000_0001,
		ST_SORT_I   = 12'b0000_0000_0010,
		ST_SORT_IW  = 12'b0000_0000_0100,
		ST_SORT_RD  = 12'b0000_0000_1000,
		ST_SORT_MUL = 12'b0000_0001_0000,
		ST_SORT_CMP = 12'b0000_0010_0000,
		ST_SORT_WB  = 12'b0000_0100_0000,
		ST_SQ       = 12'b0000_1000_0000,
		ST_AREA     = 12'b0001_0000_0000,
		ST_EDGE     = 12'b0010_0000_0000,
		ST_FIN1     = 12'b0100_0000_0000,
		ST_FIN2     = 12'b1000_0000_0000
	} state_t;

	state_t state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] loaded_q;
	logic [CW-1:0] si_q;
	logic [CW-1:0] sj_q;
	logic [FW-1:0] f_q;
	logic ph_q;
	coord_t x0_q, y0_q, ax_q, ay_q, prev_x_q, prev_y_q;
	coord_t pi_x_q, pi_y_q, cj_x_q, cj_y_q;
	diff_t dx_q, dy_q;
	logic signed [ACC_W-1:0] acc_q;
	logic sgn_neg_q;
	logic zero_q;
	logic fzero_q;
	logic [BOUND_W-1:0] lo_q, hi_q;
	logic [IFW-1:0] inflight_q;
	logic [FA_W-1:0] fa_q;
	logic [FB_W-1:0] fb_q;
	logic strobe_q;
	logic [LEN_W-1:0] len_q;

	logic av_s1, afirst_s1, am_s2;
	logic ev_s1, inj_s1, ev_s2, ev_s3, ev_s4;
	diff_t ex_s2, ey_s2, pxa_s2, pya_s2, ex_s3, ey_s3;
	cross_t c0_s4;
	prod_t p1_q, p2_q;

	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [2*COORD_W-1:0] ram_wdata, ram_rdata;
	coord_t rx, ry, cur_x, cur_y;
	diff_t ma1, mb1, ma2, mb2;
	cross_t pdiff, c0, c1;
	logic [CROSS_W-1:0] c0_mag, c1_mag;
	logic c1z, c1p, c1n, c0pos, c0neg;
	logic kill, push_lo, push_hi;
	logic issue_a, issue_e, inject;
	logic area_done, edge_done;
	logic sqrt_start, sqrt_done;
	logic [RAD_W-1:0] radicand;
	logic [ROOT_W-1:0] root;
	logic [31:0] cfg_wide, cfg_sat;
	logic [BOUND_W-1:0] dt;
	logic [SUM_W-1:0] len_sum;
	div_word_t chain [FRAC_W+1];
	logic accept;

	assign accept = start && (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);
	assign rx = ram_rdata[2*COORD_W-1:COORD_W];
	assign ry = ram_rdata[COORD_W-1:0];
	assign cur_x = inj_s1 ? x0_q : rx;
	assign cur_y = inj_s1 ? y0_q : ry;

	assign issue_a = (state_q == ST_AREA) && (FW'(count_q) > f_q);
	assign issue_e = (state_q == ST_EDGE) && !ph_q && (FW'(count_q) > f_q);
	assign inject = (state_q == ST_EDGE) && !ph_q && (FW'(count_q) == f_q);
	assign area_done = (state_q == ST_AREA) && (FW'(count_q) == f_q) && !av_s1 && !am_s2;
	assign edge_done = (state_q == ST_EDGE) && (f_q > FW'(count_q)) && !ev_s1 && !ev_s2
		&& !ev_s3 && !ev_s4 && (inflight_q == '0) && sqrt_done;
	assign sqrt_start = (state_q == ST_AREA) && (f_q == FW'(1));
	assign radicand = RAD_W'(p1_q) + RAD_W'(p2_q);

	always_comb begin
		cfg_wide = 32'(vertex_count);
		if (cfg_wide < 32'(MIN_VERTICES)) begin
			cfg_sat = 32'(MIN_VERTICES);
		end else if (cfg_wide > 32'(MAX_VERTICES)) begin
			cfg_sat = 32'(MAX_VERTICES);
		end else begin
			cfg_sat = cfg_wide;
		end
	end

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = loaded_q[AW-1:0];
		ram_wdata = {x_a, y_a};
		ram_raddr = f_q[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				ram_we = start && !mode && (loaded_q < count_q);
			end
			ST_SORT_I: begin
				ram_raddr = si_q[AW-1:0];
			end
			ST_SORT_RD: begin
				ram_raddr = sj_q[AW-1:0];
			end
			ST_SORT_CMP: begin
				ram_we = pdiff[CROSS_W-1];
				ram_waddr = sj_q[AW-1:0];
				ram_wdata = {pi_x_q, pi_y_q};
			end
			ST_SORT_WB: begin
				ram_we = 1'b1;
				ram_waddr = si_q[AW-1:0];
				ram_wdata = {pi_x_q, pi_y_q};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		if (ev_s2) begin
			ma1 = ex_s2;
			mb1 = pya_s2;
			ma2 = ey_s2;
			mb2 = pxa_s2;
		end else if (ev_s3) begin
			ma1 = ex_s3;
			mb1 = dy_q;
			ma2 = ey_s3;
			mb2 = dx_q;
		end else if (state_q == ST_SORT_MUL) begin
			ma1 = DIFF_W'(rx) - DIFF_W'(x0_q);
			mb1 = DIFF_W'(pi_y_q) - DIFF_W'(y0_q);
			ma2 = DIFF_W'(pi_x_q) - DIFF_W'(x0_q);
			mb2 = DIFF_W'(ry) - DIFF_W'(y0_q);
		end else if (av_s1) begin
			ma1 = DIFF_W'(prev_x_q) - DIFF_W'(x0_q);
			mb1 = DIFF_W'(ry) - DIFF_W'(y0_q);
			ma2 = DIFF_W'(rx) - DIFF_W'(x0_q);
			mb2 = DIFF_W'(prev_y_q) - DIFF_W'(y0_q);
		end else begin
			ma1 = dx_q;
			mb1 = dx_q;
			ma2 = dy_q;
			mb2 = dy_q;
		end
	end

	always_ff @(posedge clk) begin
		p1_q <= ma1 * mb1;
		p2_q <= ma2 * mb2;
	end

	always_comb begin
		pdiff = CROSS_W'(p1_q) - CROSS_W'(p2_q);
		c0 = sgn_neg_q ? -c0_s4 : c0_s4;
		c1 = sgn_neg_q ? -pdiff : pdiff;
		c1z = (c1 == '0);
		c1n = c1[CROSS_W-1];
		c1p = !c1z && !c1n;
		c0neg = c0[CROSS_W-1];
		c0pos = !c0neg && (c0 != '0);
		c0_mag = c0neg ? CROSS_W'(-c0) : CROSS_W'(c0);
		c1_mag = c1n ? CROSS_W'(-c1) : CROSS_W'(c1);
		kill = ev_s4 && ((c1z && !c0pos) || (c1p && c0neg && (c0_mag >= c1_mag))
			|| (c1n && !c0pos));
		push_lo = ev_s4 && c1p && c0neg && (c0_mag < c1_mag);
		push_hi = ev_s4 && c1n && c0pos && (c0_mag < c1_mag);
	end

	assign chain[0].valid = push_lo || push_hi;
	assign chain[0].is_lo = push_lo;
	assign chain[0].rem = c0_mag;
	assign chain[0].den = c1_mag;
	assign chain[0].quo = '0;

	for (genvar g = 0; g < FRAC_W; g++) begin : g_cell
		scpcl_div_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.d_in(chain[g]),
			.d_out(chain[g+1])
		);
	end

	scpcl_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(sqrt_start),
		.radicand(radicand),
		.done(sqrt_done),
		.root(root)
	);

	scpcl_ram #(
		.WIDTH(2 * COORD_W),
		.DEPTH(MAX_VERTICES)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		ex_s2 <= DIFF_W'(cur_x) - DIFF_W'(prev_x_q);
		ey_s2 <= DIFF_W'(cur_y) - DIFF_W'(prev_y_q);
		pxa_s2 <= DIFF_W'(ax_q) - DIFF_W'(prev_x_q);
		pya_s2 <= DIFF_W'(ay_q) - DIFF_W'(prev_y_q);
		ex_s3 <= ex_s2;
		ey_s3 <= ey_s2;
		c0_s4 <= pdiff;
	end

	assign dt = hi_q - lo_q;
	assign len_sum = SUM_W'(fa_q) + SUM_W'(fb_q[FB_W-1:16]) + ROUND_HALF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= CW'(MIN_VERTICES);
			loaded_q <= '0;
			si_q <= '0;
			sj_q <= '0;
			f_q <= '0;
			ph_q <= 1'b0;
			av_s1 <= 1'b0;
			afirst_s1 <= 1'b0;
			am_s2 <= 1'b0;
			ev_s1 <= 1'b0;
			inj_s1 <= 1'b0;
			ev_s2 <= 1'b0;
			ev_s3 <= 1'b0;
			ev_s4 <= 1'b0;
			inflight_q <= '0;
			strobe_q <= 1'b0;
			zero_q <= 1'b0;
			fzero_q <= 1'b0;
			sgn_neg_q <= 1'b0;
			acc_q <= '0;
			lo_q <= '0;
			hi_q <= BOUND_ONE;
			len_q <= '0;
			x0_q <= '0;
			y0_q <= '0;
			ax_q <= '0;
			ay_q <= '0;
			dx_q <= '0;
			dy_q <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
			pi_x_q <= '0;
			pi_y_q <= '0;
			cj_x_q <= '0;
			cj_y_q <= '0;
			fa_q <= '0;
			fb_q <= '0;
		end else begin
			strobe_q <= 1'b0;
			av_s1 <= issue_a;
			afirst_s1 <= (f_q == FW'(1));
			am_s2 <= av_s1 && !afirst_s1;
			ev_s1 <= issue_e || inject;
			inj_s1 <= inject;
			ev_s2 <= ev_s1;
			ev_s3 <= ev_s2;
			ev_s4 <= ev_s3;
			inflight_q <= inflight_q + IFW'(chain[0].valid) - IFW'(chain[FRAC_W].valid);

			if (cfg_we) begin
				count_q <= CW'(cfg_sat);
				loaded_q <= '0;
			end
			if (av_s1 || ev_s1) begin
				prev_x_q <= cur_x;
				prev_y_q <= cur_y;
			end
			if (am_s2) begin
				acc_q <= acc_q + ACC_W'(pdiff);
			end
			if (kill) begin
				zero_q <= 1'b1;
			end
			if (chain[FRAC_W].valid) begin
				if (chain[FRAC_W].is_lo) begin
					if ({1'b0, chain[FRAC_W].quo} > lo_q) begin
						lo_q <= {1'b0, chain[FRAC_W].quo};
					end
				end else if ({1'b0, chain[FRAC_W].quo} < hi_q) begin
					hi_q <= {1'b0, chain[FRAC_W].quo};
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (accept && !mode && (loaded_q < count_q)) begin
						if (loaded_q == '0) begin
							x0_q <= x_a;
							y0_q <= y_a;
						end
						loaded_q <= loaded_q + 1'b1;
						if (loaded_q + 1'b1 == count_q) begin
							si_q <= CW'(1);
							state_q <= ST_SORT_I;
						end
					end else if (accept && mode) begin
						if (loaded_q != count_q) begin
							strobe_q <= 1'b1;
							len_q <= '0;
						end else begin
							ax_q <= x_a;
							ay_q <= y_a;
							dx_q <= DIFF_W'(x_b) - DIFF_W'(x_a);
							dy_q <= DIFF_W'(y_b) - DIFF_W'(y_a);
							zero_q <= 1'b0;
							state_q <= ST_SQ;
						end
					end
				end
				ST_SORT_I: begin
					state_q <= ST_SORT_IW;
				end
				ST_SORT_IW: begin
					pi_x_q <= rx;
					pi_y_q <= ry;
					sj_q <= si_q + 1'b1;
					state_q <= ST_SORT_RD;
				end
				ST_SORT_RD: begin
					state_q <= ST_SORT_MUL;
				end
				ST_SORT_MUL: begin
					cj_x_q <= rx;
					cj_y_q <= ry;
					state_q <= ST_SORT_CMP;
				end
				ST_SORT_CMP: begin
					if (pdiff[CROSS_W-1]) begin
						pi_x_q <= cj_x_q;
						pi_y_q <= cj_y_q;
					end
					sj_q <= sj_q + 1'b1;
					if (sj_q + 1'b1 == count_q) begin
						state_q <= ST_SORT_WB;
					end else begin
						state_q <= ST_SORT_RD;
					end
				end
				ST_SORT_WB: begin
					si_q <= si_q + 1'b1;
					if (si_q + CW'(2) == count_q) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_SORT_I;
					end
				end
				ST_SQ: begin
					f_q <= FW'(1);
					acc_q <= '0;
					state_q <= ST_AREA;
				end
				ST_AREA: begin
					if (issue_a) begin
						f_q <= f_q + 1'b1;
					end
					if (area_done) begin
						if (acc_q == '0) begin
							zero_q <= 1'b1;
							state_q <= ST_FIN1;
						end else begin
							sgn_neg_q <= acc_q[ACC_W-1];
							f_q <= FW'(1);
							ph_q <= 1'b0;
							prev_x_q <= x0_q;
							prev_y_q <= y0_q;
							lo_q <= '0;
							hi_q <= BOUND_ONE;
							state_q <= ST_EDGE;
						end
					end
				end
				ST_EDGE: begin
					ph_q <= !ph_q;
					if (issue_e || inject) begin
						f_q <= f_q + 1'b1;
					end
					if (edge_done) begin
						state_q <= ST_FIN1;
					end
				end
				ST_FIN1: begin
					fzero_q <= zero_q || (hi_q <= lo_q);
					fa_q <= root * dt[BOUND_W-1:16];
					fb_q <= root * dt[15:0];
					state_q <= ST_FIN2;
				end
				ST_FIN2: begin
					strobe_q <= 1'b1;
					len_q <= fzero_q ? '0 : len_sum[LEN_W+15:16];
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_strobe = strobe_q;
	assign inside_length = len_q;

endmodule

FILE: rtl/core/scpcl_checker.sv
// ----------------------------------------------------------------------------
// Clip length port checker
// Checks how result words follow accepted items on the top-level ports.
// ----------------------------------------------------------------------------
`include "segment_convex_polygon_clip_length_macros.svh"

module scpcl_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic mode,
	input logic result_strobe
);

	`SCPCL_ASSERT_SAME(a_strobe_idle, clk, arst_n, result_strobe, !busy)
	`SCPCL_ASSERT_NEXT(a_load_silent, clk, arst_n, start && !busy && !mode, !result_strobe)
	`SCPCL_ASSERT_SAME(a_strobe_cause, clk, arst_n, result_strobe,
		$past(busy) || $past(start && mode))

endmodule

bind segment_convex_polygon_clip_length scpcl_checker u_scpcl_checker (.*);
